### src/dcepdu_pkg.sv
package dcepdu_pkg;

  // Header field limits of a connection-oriented PDU.
  localparam logic [7:0]  PDU_VERSION   = 8'd5;
  localparam logic [7:0]  PDU_MAX_MINOR = 8'd1;
  localparam logic [7:0]  PDU_MAX_TYPE  = 8'd19;
  localparam logic [15:0] PDU_HDR_LEN   = 16'd16;
  localparam logic [7:0]  DREP_LE_BIT   = 8'h10;

  // Byte positions inside the header.
  localparam logic [15:0] POS_VERSION = 16'd0;
  localparam logic [15:0] POS_MINOR   = 16'd1;
  localparam logic [15:0] POS_TYPE    = 16'd2;
  localparam logic [15:0] POS_DREP    = 16'd4;
  localparam logic [15:0] POS_LEN_LO  = 16'd8;
  localparam logic [15:0] POS_LEN_HI  = 16'd9;

  localparam logic [7:0] THRESHOLD_RESET = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_IN_PROCESS = 2'd0,
    VERDICT_SUCCESS    = 2'd1,
    VERDICT_NO_MATCH   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] pdu_count;
    verdict_t   verdict;
  } result_t;

endpackage

### src/dcepdu_tracker.sv
module dcepdu_tracker #(
  parameter int COUNT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           payload_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic                 from_responder,
  input  logic [7:0]           success_threshold,
  output dcepdu_pkg::result_t  result
);
  import dcepdu_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] valid_pdus, valid_pdus_next;
  logic [15:0]           offset_in_pdu, offset_in_pdu_next;
  logic [15:0]           fragment_length, fragment_length_next;
  logic [7:0]            length_low_byte, length_low_byte_next;
  logic                  little_endian, little_endian_next;
  logic                  packet_error, packet_error_next;

  logic                  start;
  logic [15:0]           pos;
  logic [15:0]           pos_inc;
  logic [15:0]           len;
  logic                  bad;
  logic [CMP_W-1:0]      count_ext;

  always_comb begin
    start = from_responder && first_byte;
    // Packet state as seen by this byte, after a clear on the first byte.
    pos                  = start ? 16'd0 : offset_in_pdu;
    offset_in_pdu_next   = pos;
    fragment_length_next = start ? 16'd0 : fragment_length;
    length_low_byte_next = start ? 8'd0 : length_low_byte;
    little_endian_next   = start ? 1'b0 : little_endian;
    packet_error_next    = start ? 1'b0 : packet_error;
    valid_pdus_next      = valid_pdus;
    pos_inc              = pos + 16'd1;
    len = little_endian_next ? {payload_byte, length_low_byte_next}
                             : {length_low_byte_next, payload_byte};
    bad = ((pos == POS_VERSION) && (payload_byte != PDU_VERSION)) ||
          ((pos == POS_MINOR) && (payload_byte > PDU_MAX_MINOR)) ||
          ((pos == POS_TYPE) && (payload_byte > PDU_MAX_TYPE)) ||
          ((pos == POS_LEN_HI) && (len < PDU_HDR_LEN));

    if (from_responder && !packet_error_next) begin
      if (bad) begin
        packet_error_next = 1'b1;
      end else begin
        if (pos == POS_DREP) begin
          little_endian_next = (payload_byte & DREP_LE_BIT) != 8'd0;
        end
        if (pos == POS_LEN_LO) begin
          length_low_byte_next = payload_byte;
        end
        if (pos == POS_LEN_HI) begin
          fragment_length_next = len;
        end
        offset_in_pdu_next = pos_inc;
        if ((pos >= POS_LEN_HI) && (pos_inc == fragment_length_next)) begin
          if (valid_pdus != COUNT_MAX) begin
            valid_pdus_next = valid_pdus + 1'b1;
          end
          offset_in_pdu_next = 16'd0;
        end
      end
    end

    count_ext        = CMP_W'(valid_pdus_next);
    result.pdu_count = count_ext[7:0];
    if (!from_responder) begin
      result.verdict = VERDICT_IN_PROCESS;
    end else if (packet_error_next || (offset_in_pdu_next != 16'd0)) begin
      result.verdict = VERDICT_NO_MATCH;
    end else if (count_ext >= CMP_W'(success_threshold)) begin
      result.verdict = VERDICT_SUCCESS;
    end else begin
      result.verdict = VERDICT_IN_PROCESS;
    end

    // The packet state is dropped after the last byte of a responder packet.
    if (from_responder && last_byte) begin
      offset_in_pdu_next   = 16'd0;
      fragment_length_next = 16'd0;
      length_low_byte_next = 8'd0;
      little_endian_next   = 1'b0;
      packet_error_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pdus      <= '0;
      offset_in_pdu   <= '0;
      fragment_length <= '0;
      length_low_byte <= '0;
      little_endian   <= 1'b0;
      packet_error    <= 1'b0;
    end else if (step) begin
      valid_pdus      <= valid_pdus_next;
      offset_in_pdu   <= offset_in_pdu_next;
      fragment_length <= fragment_length_next;
      length_low_byte <= length_low_byte_next;
      little_endian   <= little_endian_next;
      packet_error    <= packet_error_next;
    end
  end

endmodule

### src/dcerpc_pdu_stream_identifier_top.sv
// DCE/RPC connection-oriented PDU stream identifier.
//
// The slave stream (s_tvalid/s_tready) carries one payload byte per
// transaction; s_tlast marks the final byte of a packet, s_tuser[0] the first
// byte and s_tuser[1] a packet from the responder. Responder packets are cut
// into back-to-back PDUs whose 16-byte headers are checked, and a saturating
// count of complete valid PDUs is kept for the flow. Every last byte yields
// one master transaction with the verdict and the current count.
// The cfg channel writes the success threshold; it is always ready and is
// meant to be written only while the block is idle.
//
// One byte is taken every cycle while no last byte waits on a stalled
// receiver. A byte is captured in the input register and processed from
// there; a last byte's result is then captured in the result register,
// which drives m_tvalid. When the receiver
// stalls, the result register holds its transaction; bytes that produce no
// result still flow through, and the next last byte waits in the input
// register, which then holds s_tready low until the result register frees.
// Reset clears the count, the packet tracking and both register stages and
// sets the threshold back to 3.
module dcerpc_pdu_stream_identifier_top #(
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload_byte
  input  logic        s_tlast,   // last_byte
  input  logic [1:0]  s_tuser,   // [0] first_byte, [1] from_responder
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] verdict, [9:2] pdu_count, rest zero
  // Threshold register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // success_threshold
);
  import dcepdu_pkg::*;

  logic [7:0] success_threshold;

  // Input register stage.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_last;
  logic       in_resp;

  logic       out_free;
  logic       step;
  result_t    result;
  result_t    out_result;

  // A byte that makes no result never waits on the master side.
  assign out_free  = !m_tvalid || m_tready;
  assign step      = in_full && (!in_last || out_free);
  assign s_tready  = !in_full || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      success_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      success_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
      in_last  <= s_tlast;
      in_resp  <= s_tuser[1];
    end
  end

  dcepdu_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .payload_byte     (in_byte),
    .first_byte       (in_first),
    .last_byte        (in_last),
    .from_responder   (in_resp),
    .success_threshold(success_threshold),
    .result           (result)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {6'd0, out_result.pdu_count, out_result.verdict};

endmodule

### sim/dcerpc_pdu_stream_identifier_top_tb.sv
module dcerpc_pdu_stream_identifier_top_tb;
  import dcepdu_pkg::*;

  localparam int COUNT_BITS  = 8;
  // Cycle limit for the whole run, saturation fill included.
  localparam int CYCLE_LIMIT = 400000;
  // Margin waited after the last owed verdict has left.
  localparam int DRAIN_CYCLES = 6;
  localparam int PROBE_ROWS   = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic [1:0]  s_tuser = 2'b00;     // [0] first_byte, [1] from_responder
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;             // [1:0] verdict, [9:2] pdu_count
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  dcerpc_pdu_stream_identifier_top #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Flow tracking as the block should hold it. The predictor below updates it
  // on every accepted input transaction, at the clock edge of acceptance.
  logic [COUNT_BITS-1:0] flow_pdus = '0;
  logic [15:0]           pdu_pos = '0;
  logic [15:0]           frag_len = '0;
  logic [7:0]            len_low = '0;
  logic                  drep_le = 1'b0;
  logic                  pkt_failed = 1'b0;
  logic [7:0]            threshold = THRESHOLD_RESET;

  // Verdicts owed by the block, oldest first.
  result_t verdicts_due[$];

  int mismatches = 0;
  int cycles = 0;
  int resp_bytes = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;

  // Packet under construction and the offsets where its PDUs begin.
  logic [7:0] pkt[$];
  int         pdu_starts[$];

  function automatic void clear_tracking();
    pdu_pos    = '0;
    frag_len   = '0;
    len_low    = '0;
    drep_le    = 1'b0;
    pkt_failed = 1'b0;
  endfunction

  // Consumes one payload byte; returns 1 when the byte yields a verdict.
  function automatic bit identify_byte(input logic [7:0] b, input bit first,
                                       input bit last, input bit resp,
                                       output result_t verdict_out);
    logic [15:0] pos;
    logic [15:0] len;
    bit          hdr_ok;
    pos = pdu_pos;
    len = '0;
    hdr_ok = 1'b1;
    verdict_out = '0;
    if (resp) begin
      if (first) clear_tracking();
      if (!pkt_failed) begin
        pos = pdu_pos;
        if ((pos == POS_VERSION && b != PDU_VERSION) ||
            (pos == POS_MINOR && b > PDU_MAX_MINOR) ||
            (pos == POS_TYPE && b > PDU_MAX_TYPE)) hdr_ok = 1'b0;
        if (hdr_ok && pos == POS_DREP) drep_le = (b & DREP_LE_BIT) != 8'h00;
        if (hdr_ok && pos == POS_LEN_LO) len_low = b;
        if (hdr_ok && pos == POS_LEN_HI) begin
          len = drep_le ? {b, len_low} : {len_low, b};
          if (len < PDU_HDR_LEN) hdr_ok = 1'b0;
          else frag_len = len;
        end
        if (!hdr_ok) begin
          pkt_failed = 1'b1;
        end else begin
          pdu_pos = pos + 16'd1;
          if (pos >= POS_LEN_HI && pdu_pos == frag_len) begin
            if (flow_pdus != '1) flow_pdus = flow_pdus + 1'b1;
            pdu_pos = '0;
          end
        end
      end
    end
    if (!last) return 1'b0;
    verdict_out.verdict = VERDICT_IN_PROCESS;
    if (resp) begin
      if (pkt_failed || pdu_pos != 16'd0) verdict_out.verdict = VERDICT_NO_MATCH;
      else if (flow_pdus >= threshold) verdict_out.verdict = VERDICT_SUCCESS;
      clear_tracking();
    end
    verdict_out.pdu_count = 8'(flow_pdus);
    return 1'b1;
  endfunction

  // Directed probes. Where a row is marked typed, its verdict and count are
  // the ones written here rather than the predictor's.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       resp;
    logic       typed;
    verdict_t   verdict;
    logic [7:0] count;
  } probe_row_t;

  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    // An initiator packet is ignored and reports the count as it stands.
    '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1, VERDICT_IN_PROCESS, 8'd0},
    // A one-byte responder packet ends inside the header.
    '{8'h05, 1'b1, 1'b1, 1'b1, 1'b1, VERDICT_NO_MATCH,   8'd0},
    // Minimal 16-byte PDU: top minor version and type, little-endian length.
    '{8'h05, 1'b1, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h01, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h13, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h03, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h10, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h10, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'hAA, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h55, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    // Wrong version byte.
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, VERDICT_NO_MATCH,   8'd1},
    // Packet without its first marker still starts a fresh header.
    '{8'h05, 1'b0, 1'b1, 1'b1, 1'b1, VERDICT_NO_MATCH,   8'd1},
    // Minor version too high.
    '{8'h05, 1'b1, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h02, 1'b0, 1'b1, 1'b1, 1'b1, VERDICT_NO_MATCH,   8'd1},
    // Packet type too high.
    '{8'h05, 1'b1, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h01, 1'b0, 1'b0, 1'b1, 1'b0, VERDICT_IN_PROCESS, 8'd0},
    '{8'h14, 1'b0, 1'b1, 1'b1, 1'b1, VERDICT_NO_MATCH,   8'd1}
  };

  // Offers one byte, waits for the transaction and records what it owes.
  task automatic push_byte(input logic [7:0] b, input bit first, input bit last,
                           input bit resp, input bit typed, input result_t typed_val);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= {resp, first};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (resp) resp_bytes++;
    if (identify_byte(b, first, last, resp, predicted))
      verdicts_due.push_back(typed ? typed_val : predicted);
  endtask

  task automatic send_pkt(input bit resp, input bit no_first);
    for (int i = 0; i < pkt.size(); i++)
      push_byte(pkt[i], i == 0 && !no_first, i == pkt.size() - 1, resp, 1'b0, '0);
  endtask

  // Sender stops and waits until the block owes nothing more.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_pdu_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(24, 16);
    if (r < 95) return $urandom_range(64, 25);
    return $urandom_range(300, 65);
  endfunction

  // Appends one well-formed PDU of the given total length with random content.
  task automatic add_pdu(input int len);
    bit         le;
    logic [7:0] drep;
    logic [15:0] l16;
    le   = 1'($urandom_range(1));
    drep = 8'($urandom_range(255));
    l16  = 16'(len);
    pdu_starts.push_back(pkt.size());
    pkt.push_back(PDU_VERSION);
    pkt.push_back(8'($urandom_range(1)));
    pkt.push_back(8'($urandom_range(19)));
    pkt.push_back(8'($urandom_range(255)));
    pkt.push_back(le ? (drep | DREP_LE_BIT) : (drep & ~DREP_LE_BIT));
    repeat (3) pkt.push_back(8'($urandom_range(255)));
    pkt.push_back(le ? l16[7:0] : l16[15:8]);
    pkt.push_back(le ? l16[15:8] : l16[7:0]);
    for (int i = 10; i < len; i++) pkt.push_back(8'($urandom_range(255)));
  endtask

  // One random packet: mostly well-formed runs of PDUs, some damaged ones,
  // some initiator traffic and some marker noise.
  task automatic random_packet();
    int         sel;
    int         at;
    int         n;
    bit         no_first;
    bit         relen;
    logic [7:0] v;
    logic [15:0] new_len;
    sel = $urandom_range(99);
    no_first = 1'b0;
    relen = 1'b0;
    new_len = '0;
    pkt.delete();
    pdu_starts.delete();
    if (sel < 10) begin
      n = $urandom_range(24, 1);
      repeat (n) pkt.push_back(8'($urandom_range(255)));
      send_pkt(1'b0, 1'b0);
    end else if (sel < 15) begin
      // Markers at random places, first markers in mid-packet included.
      n = $urandom_range(12, 1);
      at = $urandom_range(1);
      repeat (n)
        push_byte($urandom_range(3) == 0 ? PDU_VERSION : 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'(at), 1'b0, '0);
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) add_pdu(pick_pdu_len());
      if (sel >= 70) begin
        at = pdu_starts[$urandom_range(pdu_starts.size() - 1)];
        case ($urandom_range(7))
          0: begin
            v = 8'($urandom_range(255));
            pkt[at] = (v == PDU_VERSION) ? ~v : v;
          end
          1: pkt[at + 1] = 8'($urandom_range(255, 2));
          2: pkt[at + 2] = 8'($urandom_range(255, 20));
          3: begin
            new_len = 16'($urandom_range(15));
            relen = 1'b1;
          end
          4: begin
            // Mostly longer than what follows: the packet then ends mid-PDU.
            new_len = 16'($urandom_range(65535, 512));
            relen = 1'b1;
          end
          5: begin
            n = $urandom_range(pkt.size() - 1, 1);
            repeat (n) void'(pkt.pop_back());
          end
          6: begin
            pkt.push_back(PDU_VERSION);
            n = $urandom_range(14);
            repeat (n) pkt.push_back(8'($urandom_range(255)));
          end
          default: no_first = 1'b1;
        endcase
        if (relen) begin
          if ((pkt[at + 4] & DREP_LE_BIT) != 8'h00) begin
            pkt[at + 8] = new_len[7:0];
            pkt[at + 9] = new_len[15:8];
          end else begin
            pkt[at + 8] = new_len[15:8];
            pkt[at + 9] = new_len[7:0];
          end
        end
      end
      send_pkt(1'b1, no_first);
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = resp_bytes;
    while (resp_bytes - start < budget) random_packet();
  endtask

  // Receiver: a requested hold-off keeps tready low for that many cycles;
  // otherwise it stalls at the rate of the current phase.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Every result transaction is matched against the oldest verdict owed.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[9:0]);
      if (verdicts_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: verdict %0d count %0d", got.verdict,
                   got.pdu_count);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.verdict !== want.verdict || got.pdu_count !== want.pdu_count ||
            m_tdata[15:10] !== 6'd0) begin
          if (mismatches < 10)
            $display("result mismatch: verdict %0d/%0d count %0d/%0d pad %h (exp/act)",
                     want.verdict, got.verdict, want.pdu_count, got.pdu_count,
                     m_tdata[15:10]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog for a hung handshake or a verdict that never arrives.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL dcerpc_pdu_stream_identifier_top");
      $finish;
    end
  end

  initial begin
    logic [7:0] thr;
    snd_idle_pct = 22;
    rcv_idle_pct = 76;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed probes run at the reset threshold.
    for (int i = 0; i < PROBE_ROWS; i++)
      push_byte(PROBES[i].data, PROBES[i].first, PROBES[i].last, PROBES[i].resp,
                PROBES[i].typed, '{pdu_count: PROBES[i].count,
                                  verdict: PROBES[i].verdict});
    wait_drained();

    // Lowest threshold: nearly every clean packet is a success.
    write_threshold(8'd1);
    run_random(700);
    wait_drained();

    // Highest threshold, with the idling rates swapped.
    snd_idle_pct = 76;
    rcv_idle_pct = 22;
    write_threshold(8'd255);
    run_random(700);
    wait_drained();

    // Threshold just above the running count, so the verdict flips from in
    // process to success during the phase. No idling here; instead the
    // receiver holds off long enough for the block to stall its input.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    thr = (flow_pdus > 250) ? 8'd255 : 8'(flow_pdus) + 8'd5;
    write_threshold(thr);
    hold_left = 300;
    run_random(300);
    wait_drained();
    hold_left = 300;
    run_random(300);
    wait_drained();

    // Pack PDUs of 16 to 18 bytes until the count saturates, then a few more
    // packets to show it stays there.
    write_threshold(8'd255);
    while (flow_pdus != '1) begin
      pkt.delete();
      pdu_starts.delete();
      repeat ($urandom_range(6, 1)) add_pdu($urandom_range(18, 16));
      send_pkt(1'b1, 1'b0);
    end
    repeat (5) begin
      pkt.delete();
      pdu_starts.delete();
      repeat ($urandom_range(3, 1)) add_pdu(16);
      send_pkt(1'b1, 1'b0);
    end
    wait_drained();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("PASS dcerpc_pdu_stream_identifier_top");
    end else begin
      $display("FAIL dcerpc_pdu_stream_identifier_top");
    end
    $finish;
  end

endmodule
